[design/setpoint_waveform_generator_assert.svh]
// ----------------------------------------------------------------------------
// Setpoint waveform generator assertion macros
// Shared forms for the concurrent checks of the generator.
// ----------------------------------------------------------------------------
`ifndef SETPOINT_WAVEFORM_GENERATOR_ASSERT_SVH
`define SETPOINT_WAVEFORM_GENERATOR_ASSERT_SVH

// Check a consequence in the same cycle as its condition.
`define SWG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("setpoint generator check failed");

// Check a consequence in the cycle after its condition.
`define SWG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("setpoint generator check failed");

`endif

[design/swg_pkg.sv]
// ----------------------------------------------------------------------------
// Setpoint waveform generator package
// Register indexes, waveform codes and sequencer states.
// ----------------------------------------------------------------------------
package swg_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_KIND   = 3'd0;
    localparam logic [2:0] REG_AMP    = 3'd1;
    localparam logic [2:0] REG_OFFSET = 3'd2;
    localparam logic [2:0] REG_DUTY   = 3'd3;
    localparam logic [2:0] REG_PERIOD = 3'd4;

    // Waveform kinds; the fourth code acts as constant
    localparam logic [1:0] KIND_CONST  = 2'd0;
    localparam logic [1:0] KIND_SINE   = 2'd1;
    localparam logic [1:0] KIND_SQUARE = 2'd2;

    // Widths fixed by the register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int SAMPLE_W   = 17;
    localparam int MAG_W      = 15;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ROM,
        S_MUL,
        S_SQR,
        S_FIN,
        S_DONE
    } seq_state_t;

endpackage

[design/setpoint_waveform_generator.sv]
// ----------------------------------------------------------------------------
// Setpoint waveform generator
// One constant, sine or square setpoint word per input word, scaled by a
// signed amplitude and shifted by a signed offset, with a wrapping position.
// ----------------------------------------------------------------------------
// An input word goes from acceptance through the sequencer states to S_DONE:
// a constant sample, or any at a zero period, goes straight there; a square
// sample passes S_SQR and S_FIN, a sine sample S_DIV, S_ROM, S_MUL and S_FIN.
// There the sample is loaded into the output register on the return to idle.
// A sine sample passes the bit-serial phase divider, which produces one
// quotient bit per cycle, followed by the registered quarter-wave table read,
// the amplitude multiply and the rounding stage. The input side is stalled
// while a word is at work; a finished sample waits in the output register so
// that the next word can be taken before the sample is consumed. Configuration
// writes are taken in any cycle and are meant for idle periods only; writing
// the period clears the position.
// ----------------------------------------------------------------------------
`include "setpoint_waveform_generator_assert.svh"

module setpoint_waveform_generator #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int PERIOD_BITS     = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // configuration write channel
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [swg_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [swg_pkg::CFG_DATA_W-1:0]           cfg_data,
    // input channel
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     advance,
    // output channel
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [swg_pkg::SAMPLE_W-1:0]      sample
);

    import swg_pkg::*;

    localparam int PER_W   = (PERIOD_BITS < 16) ? PERIOD_BITS : 16;
    localparam int QB      = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QB;
    localparam int CNT_W   = $clog2(SINE_TABLE_BITS + 1);
    localparam int SQ_W    = PER_W + 17;

    typedef logic [MAG_W-1:0] sine_rom_t [QUARTER+1];

    // Build the quarter-wave magnitude table from the fixed-point polynomial
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] h;
        logic [63:0] s;
        logic [63:0] mag;
        logic [63:0] one_q30;
        one_q30 = 64'd1 << 30;
        for (int m = 0; m <= QUARTER; m++) begin
            x = 64'(m) << (30 - QB);
            t = (x * 64'd1686629713) >> 30;
            u = (t * t) >> 30;
            h = one_q30 - u / 64'd72;
            h = one_q30 - ((u * h) >> 30) / 64'd42;
            h = one_q30 - ((u * h) >> 30) / 64'd20;
            h = one_q30 - ((u * h) >> 30) / 64'd6;
            s = (t * h) >> 30;
            mag = (s + 64'd16384) >> 15;
            if (mag > 64'd32767) begin
                mag = 64'd32767;
            end
            rom[m] = mag[MAG_W-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    seq_state_t state_reg, state_next;

    logic [1:0]                 kind_reg, kind_next;
    logic signed [15:0]         amp_reg, amp_next;
    logic signed [15:0]         off_reg, off_next;
    logic [16:0]                duty_reg, duty_next;
    logic [PER_W-1:0]           period_reg, period_next;
    logic [PER_W-1:0]           pos_reg, pos_next;
    logic                       adv_reg, adv_next;
    logic [PER_W-1:0]           rem_reg, rem_next;
    logic [SINE_TABLE_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [MAG_W-1:0]           rom_reg;
    logic                       neg_reg;
    logic signed [31:0]         prod_reg;
    logic [SQ_W-1:0]            sq_prod_reg;
    logic signed [SAMPLE_W-1:0] value_reg, value_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;

    logic                       cfg_wr;
    logic                       in_acc;
    logic                       out_free;
    logic                       load_out;
    logic [PER_W:0]             rem_shift;
    logic                       rem_ge;
    logic [1:0]                 quad;
    logic [QB-1:0]              quad_rem;
    logic [QB:0]                rom_addr;
    logic signed [15:0]         entry;
    logic signed [32:0]         prod_round;
    logic signed [17:0]         sine_sum;
    logic signed [SAMPLE_W-1:0] sine_value;
    logic signed [SAMPLE_W-1:0] square_value;
    logic                       square_high;
    logic [PER_W:0]             pos_inc;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // Divider step: shift the remainder and trial-subtract the period
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, period_reg});

    // Fold the phase index onto the quarter wave
    assign quad     = quo_reg[SINE_TABLE_BITS-1:QB];
    assign quad_rem = quo_reg[QB-1:0];
    assign rom_addr = quad[0] ? ((QB+1)'(QUARTER) - {1'b0, quad_rem}) : {1'b0, quad_rem};

    // Apply the half-wave sign to the table magnitude
    assign entry = neg_reg ? -$signed({1'b0, rom_reg}) : $signed({1'b0, rom_reg});

    // Round the amplitude times Q1.15 entry product back to Q8.8 and add the offset
    assign prod_round = 33'(prod_reg) + 33'sd16384;
    assign sine_sum   = prod_round[32:15] + 18'(off_reg);
    assign sine_value = sine_sum[SAMPLE_W-1:0];

    // Square level: high while position * 65536 < duty * period
    assign square_high  = ({1'b0, pos_reg, 16'b0} < sq_prod_reg);
    assign square_value = square_high ? (SAMPLE_W'(amp_reg) + SAMPLE_W'(off_reg))
                                      : SAMPLE_W'(off_reg);

    assign pos_inc = {1'b0, pos_reg} + (PER_W+1)'(1);

    // Sequencer: next state and handshake
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc) begin
                    if (period_reg == '0) begin
                        state_next = S_DONE;
                    end else if (kind_reg == KIND_SINE) begin
                        state_next = S_DIV;
                    end else if (kind_reg == KIND_SQUARE) begin
                        state_next = S_SQR;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = S_ROM;
                end
            end
            S_ROM:   state_next = S_MUL;
            S_MUL:   state_next = S_FIN;
            S_SQR:   state_next = S_FIN;
            S_FIN:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        kind_next      = kind_reg;
        amp_next       = amp_reg;
        off_next       = off_reg;
        duty_next      = duty_reg;
        period_next    = period_reg;
        pos_next       = pos_reg;
        adv_next       = adv_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;

        // drop the sample once taken
        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc) begin
                    adv_next   = advance;
                    rem_next   = pos_reg;
                    quo_next   = '0;
                    cnt_next   = CNT_W'(SINE_TABLE_BITS);
                    value_next = SAMPLE_W'(off_reg);
                end
            end
            S_DIV:
            begin
                rem_next = rem_ge ? PER_W'(rem_shift - {1'b0, period_reg})
                                  : rem_shift[PER_W-1:0];
                quo_next = {quo_reg[SINE_TABLE_BITS-2:0], rem_ge};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            S_FIN:
            begin
                value_next = (kind_reg == KIND_SINE) ? sine_value : square_value;
            end
            S_DONE:
            begin
                if (load_out) begin
                    out_valid_next = 1'b1;
                    sample_next    = value_reg;
                    // advance the position and wrap at the period
                    if (adv_reg) begin
                        if (pos_inc >= {1'b0, period_reg}) begin
                            pos_next = '0;
                        end else begin
                            pos_next = pos_inc[PER_W-1:0];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        // take configuration words
        if (cfg_wr) begin
            case (cfg_index)
                REG_KIND:   kind_next = cfg_data[1:0];
                REG_AMP:    amp_next  = cfg_data[15:0];
                REG_OFFSET: off_next  = cfg_data[15:0];
                REG_DUTY:   duty_next = cfg_data[16:0];
                REG_PERIOD:
                begin
                    period_next = cfg_data[PER_W-1:0];
                    pos_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            kind_reg      <= KIND_CONST;
            amp_reg       <= 16'sd256;
            off_reg       <= '0;
            duty_reg      <= 17'd32768;
            period_reg    <= PER_W'(5);
            pos_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            amp_reg       <= amp_next;
            off_reg       <= off_next;
            duty_reg      <= duty_next;
            period_reg    <= period_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, table read and products
    always_ff @(posedge clk)
    begin
        adv_reg    <= adv_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        value_reg  <= value_next;
        sample_reg <= sample_next;
        if (state_reg == S_ROM) begin
            rom_reg <= SINE_ROM[rom_addr];
            neg_reg <= quad[1];
        end
        if (state_reg == S_MUL) begin
            prod_reg <= amp_reg * entry;
        end
        if (state_reg == S_SQR) begin
            sq_prod_reg <= duty_reg * period_reg;
        end
    end

    // Position stays inside the period
    `SWG_ASSERT_SAME(a_pos_in_period, clk, rst_n, period_reg != '0, pos_reg < period_reg)
    // Divider remainder stays below the divisor
    `SWG_ASSERT_SAME(a_rem_in_range, clk, rst_n, state_reg == S_DIV, rem_reg < period_reg)
    // Input is only taken by an idle sequencer
    `SWG_ASSERT_SAME(a_ready_idle, clk, rst_n, !in_stall, state_reg == S_IDLE)
    // Finishing a word always presents a sample
    `SWG_ASSERT_NEXT(a_done_loads, clk, rst_n, state_reg == S_DONE && out_free, out_valid_reg)

endmodule

[bench/setpoint_waveform_generator_tb.sv]
// ----------------------------------------------------------------------------
// Setpoint waveform generator testbench
// Drives tick words and register writes into the generator, predicts every
// setpoint word from a bit-accurate model kept here, and checks the samples
// in order. A short table of directed cases comes first, then randomized
// phases with random register settings, random idling and one long output
// hold-off.
// ----------------------------------------------------------------------------
module setpoint_waveform_generator_tb;

    import swg_pkg::*;

    localparam int TABLE_BITS   = 10;
    localparam int HALF_PERIOD  = 5;
    localparam int SETTLE       = 4;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASES       = 12;
    localparam int DIR_ROWS     = 35;

    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned QUARTER     = 64'd1 << (TABLE_BITS - 2);

    // Codes the package does not name
    localparam logic [1:0]           KIND_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic { ROW_CFG, ROW_WORD } row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [CFG_IDX_W-1:0]        index;
        logic [CFG_DATA_W-1:0]       data;
        logic                        adv;
        logic                        pinned;
        logic signed [SAMPLE_W-1:0]  value;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic                        advance;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [SAMPLE_W-1:0]  sample;

    // Predictor copy of the registers and the position
    logic [1:0]                  wave_kind;
    logic [15:0]                 wave_amp;
    logic [15:0]                 wave_offset;
    logic [16:0]                 wave_duty;
    logic [15:0]                 wave_period;
    logic [15:0]                 wave_pos;

    logic signed [SAMPLE_W-1:0]  setpoint_q [$];
    logic signed [SAMPLE_W-1:0]  expected_sample;
    int                          errors = 0;
    int                          idle_cycles = 0;
    bit                          calm = 1'b0;
    bit                          hold_request = 1'b0;

    // Directed cases; a typed value is used where it is plain from the setup
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b1, 17'sd0},
        '{ROW_CFG,  REG_OFFSET, 17'h07FFF,            1'b0, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b0, 1'b1, 17'sd32767},
        '{ROW_CFG,  REG_OFFSET, 17'h18000,            1'b0, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b1, -17'sd32768},
        '{ROW_CFG,  REG_KIND,   {15'd0, KIND_SPARE},  1'b0, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b1, -17'sd32768},
        '{ROW_CFG,  REG_UNUSED, 17'h1FFFF,            1'b0, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b0, 1'b1, -17'sd32768},
        '{ROW_CFG,  REG_KIND,   {15'd0, KIND_SQUARE}, 1'b0, 1'b0, 17'sd0},
        '{ROW_CFG,  REG_AMP,    17'h08000,            1'b0, 1'b0, 17'sd0},
        '{ROW_CFG,  REG_DUTY,   17'h10000,            1'b0, 1'b0, 17'sd0},
        // most negative square sample
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b1, 17'h10000},
        '{ROW_CFG,  REG_AMP,    17'h07FFF,            1'b0, 1'b0, 17'sd0},
        '{ROW_CFG,  REG_OFFSET, 17'h07FFF,            1'b0, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b1, 17'sd65534},
        // duty past full scale stays high
        '{ROW_CFG,  REG_DUTY,   17'h1FFFF,            1'b0, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b1, 17'sd65534},
        '{ROW_CFG,  REG_DUTY,   17'h00000,            1'b0, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b1, 17'sd32767},
        // zero period gives the offset alone
        '{ROW_CFG,  REG_PERIOD, 17'h00000,            1'b0, 1'b0, 17'sd0},
        '{ROW_CFG,  REG_KIND,   {15'd0, KIND_SINE},   1'b0, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b1, 17'sd32767},
        // four-step sine: zero, peak, zero, trough, then wrap
        '{ROW_CFG,  REG_PERIOD, 17'h10004,            1'b0, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b1, 17'sd32767},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b1, 17'sd32767},
        '{ROW_CFG,  REG_AMP,    17'h08000,            1'b0, 1'b0, 17'sd0},
        '{ROW_CFG,  REG_OFFSET, 17'h00000,            1'b0, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b0, 1'b0, 17'sd0},
        '{ROW_WORD, REG_KIND,   17'h00000,            1'b1, 1'b0, 17'sd0}
    };

    setpoint_waveform_generator #(
        .SINE_TABLE_BITS (TABLE_BITS),
        .PERIOD_BITS     (16)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Quarter-wave polynomial sine, Q1.15, for phase index k
    function automatic longint sine_lookup(input longint unsigned k);
        longint unsigned quad;
        longint unsigned r;
        longint unsigned m;
        longint unsigned t;
        longint unsigned u;
        longint unsigned h;
        longint unsigned mag;
        quad = (k >> (TABLE_BITS - 2)) & 64'd3;
        r    = k & (QUARTER - 1);
        m    = quad[0] ? QUARTER - r : r;
        t    = ((m << (30 - (TABLE_BITS - 2))) * HALF_PI_Q30) >> 30;
        u    = (t * t) >> 30;
        h    = ONE_Q30 - u / 72;
        h    = ONE_Q30 - ((u * h) >> 30) / 42;
        h    = ONE_Q30 - ((u * h) >> 30) / 20;
        h    = ONE_Q30 - ((u * h) >> 30) / 6;
        mag  = ((((t * h) >> 30)) + (64'd1 << 14)) >> 15;
        if (mag > 64'd32767)
            mag = 64'd32767;
        return quad[1] ? -longint'(mag) : longint'(mag);
    endfunction

    // Work out the sample for the current position, then move the position on
    function automatic logic signed [SAMPLE_W-1:0] predict_setpoint(input logic adv);
        longint          amp;
        longint          off;
        longint          value;
        longint          prod;
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned lhs;
        longint unsigned rhs;
        amp   = $signed(wave_amp);
        off   = $signed(wave_offset);
        value = off;
        pos   = wave_pos;
        if (wave_period != '0)
        begin
            if (wave_kind == KIND_SINE)
            begin
                idx   = (pos << TABLE_BITS) / wave_period;
                prod  = amp * sine_lookup(idx);
                value = ((prod + 16384) >>> 15) + off;
            end
            else if (wave_kind == KIND_SQUARE)
            begin
                lhs = pos << 16;
                rhs = wave_duty;
                rhs = rhs * wave_period;
                if (lhs < rhs)
                    value = amp + off;
            end
        end
        if (adv)
        begin
            if (pos + 1 >= wave_period)
                wave_pos = '0;
            else
                wave_pos = wave_pos + 16'd1;
        end
        return value[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic signed [SAMPLE_W-1:0] got,
                                   input logic signed [SAMPLE_W-1:0] want);
        if (errors < 40)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Offer one register write and hold it until taken; caller drops valid
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_KIND:   wave_kind   = data[1:0];
            REG_AMP:    wave_amp    = data[15:0];
            REG_OFFSET: wave_offset = data[15:0];
            REG_DUTY:   wave_duty   = data;
            REG_PERIOD:
            begin
                wave_period = data[15:0];
                wave_pos    = '0;
            end
            default: ;
        endcase
    endtask

    // Offer one tick word, optionally after a short gap, and queue its sample
    task automatic send_word(input logic adv, input logic pinned,
                             input logic signed [SAMPLE_W-1:0] pinned_value);
        logic signed [SAMPLE_W-1:0] predicted;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        advance  <= adv;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_setpoint(adv);
        setpoint_q.push_back(pinned ? pinned_value : predicted);
    endtask

    // Drop the input and let every outstanding sample come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (setpoint_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Stimulus: reset, directed table, then random phases
    initial
    begin
        int               words;
        logic [1:0]       kind;
        logic [15:0]      amp;
        logic [15:0]      off;
        logic [16:0]      duty;
        logic [15:0]      period;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        advance   <= 1'b0;
        wave_kind   = KIND_CONST;
        wave_amp    = 16'd256;
        wave_offset = '0;
        wave_duty   = 17'd32768;
        wave_period = 16'd5;
        wave_pos    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIR_ROWS; row++)
        begin
            if (directed_rows[row].kind == ROW_CFG)
            begin
                if (row == 0 || directed_rows[row - 1].kind != ROW_CFG)
                    wait_idle();
                write_reg(directed_rows[row].index, directed_rows[row].data);
                if (row == DIR_ROWS - 1 || directed_rows[row + 1].kind != ROW_CFG)
                    cfg_valid <= 1'b0;
            end
            else
            begin
                send_word(directed_rows[row].adv, directed_rows[row].pinned,
                          directed_rows[row].value);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            calm = (phase >= PHASES - 2);
            kind = 2'(phase);
            case ($urandom_range(0, 3))
                0:       amp = 16'h7FFF;
                1:       amp = 16'h8000;
                default: amp = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       off = 16'h7FFF;
                1:       off = 16'h8000;
                default: off = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       duty = 17'h00000;
                1:       duty = 17'h10000;
                2:       duty = 17'($urandom_range(65537, 131071));
                default: duty = 17'($urandom_range(0, 65536));
            endcase
            case ($urandom_range(0, 9))
                0:       period = 16'h0000;
                1:       period = 16'hFFFF;
                2:       period = 16'($urandom);
                3:       period = 16'h0001;
                default: period = 16'($urandom_range(2, 40));
            endcase
            // Spare upper data bits carry noise that the block must ignore
            write_reg(REG_KIND,   {15'($urandom), kind});
            write_reg(REG_AMP,    {1'($urandom), amp});
            write_reg(REG_OFFSET, {1'($urandom), off});
            write_reg(REG_DUTY,   duty);
            write_reg(REG_PERIOD, {1'($urandom), period});
            cfg_valid <= 1'b0;
            if (phase == 2)
                hold_request = 1'b1;
            words = $urandom_range(30, 50);
            for (int i = 0; i < words; i++)
                send_word($urandom_range(0, 3) != 0, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (setpoint_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, none near the end
    initial
    begin
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(1, 4) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Check each taken sample against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (setpoint_q.size() == 0)
            begin
                report_mismatch("sample with none expected", sample, '0);
            end
            else
            begin
                expected_sample = setpoint_q.pop_front();
                if (sample !== expected_sample)
                    report_mismatch("sample mismatch", sample, expected_sample);
            end
        end
    end

    // Watchdog: end the run if no word moves on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule

[filelist.f]
+incdir+design
design/swg_pkg.sv
design/setpoint_waveform_generator.sv
bench/setpoint_waveform_generator_tb.sv
